FILE: src/fsact_pkg.sv
// fsact_pkg: shared constants, types and codes for the fifo cache tag directory
// no dependencies; every other file in src refers to it by scoped names
`default_nettype none
package fsact_pkg;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int ADDR_BITS   = 32;

  localparam int OFF_W   = $clog2(BLOCK_BYTES);
  localparam int SET_W   = $clog2(SETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int CNT_W   = $clog2(WAYS + 1);
  localparam int TAG_W   = ADDR_BITS - OFF_W - SET_W;
  localparam int SLOT_W  = SET_W + WAY_W;
  localparam int SLOTS   = SETS * WAYS;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_SPARE = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    OUT_HIT            = 3'd0,
    OUT_MISS           = 3'd1,
    OUT_NONE_REPLACED  = 3'd2,
    OUT_CLEAN_REPLACED = 3'd3,
    OUT_DIRTY_REPLACED = 3'd4
  } outcome_t;

  // one way of the directory
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             dirty;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    entry_t            data;
  } tag_wr_t;

  // per-set fill count and oldest-way pointer
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [WAY_W-1:0] ptr;
  } meta_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
    meta_t            data;
  } meta_wr_t;

endpackage
`default_nettype wire

FILE: src/fifo_set_assoc_cache_tags_core.sv
// fifo_set_assoc_cache_tags_core: top level of the fifo-replacement tag directory
// depends on fsact_pkg, fsact_tag_ram, fsact_meta_ram and fsact_ctrl
//
// usage
//   input channel: in_valid / in_stall with req_type, addr and fill_dirty.
//   a request is taken when in_valid is high and in_stall low. in_stall is
//   high while a request is being worked on.
//   output channel: out_valid / out_stall with outcome; one result per request.
//   sequencing
//   a fill reads the set's meta entry and writes the new way, first reading
//   the oldest way for its dirty bit when the set is full; a lookup compares
//   up to 4 ways, newest first, and stops at the first match. the single tag
//   ram read port and the one comparator behind it compare one way per cycle.
//   the result sits in an output register, so the next request is taken
//   while an earlier result still waits; a request only stalls at its
//   final step if that register is still full.
//   reset: synchronous, clears control state and the per-set valid bits,
//   so every set reads as empty; no clearing pass is needed.
`default_nettype none
module fifo_set_assoc_cache_tags_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       req_type,
  input  wire logic [fsact_pkg::ADDR_BITS-1:0]  addr,
  input  wire logic                             fill_dirty,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [2:0]                            outcome
);

  logic                              idle;
  logic                              out_free;
  logic                              done;
  fsact_pkg::outcome_t               res;
  fsact_pkg::outcome_t               out_res;
  logic [fsact_pkg::SET_W-1:0]       meta_raddr;
  fsact_pkg::meta_t                  meta_rdata;
  fsact_pkg::meta_wr_t               meta_wr;
  logic [fsact_pkg::SLOT_W-1:0]      tag_raddr;
  fsact_pkg::entry_t                 tag_rdata;
  fsact_pkg::tag_wr_t                tag_wr;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !idle;
  assign outcome  = out_res;

  fsact_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .idle       (idle),
    .req_type   (req_type),
    .addr       (addr),
    .fill_dirty (fill_dirty),
    .out_free   (out_free),
    .done       (done),
    .res        (res),
    .meta_raddr (meta_raddr),
    .meta_rdata (meta_rdata),
    .meta_wr    (meta_wr),
    .tag_raddr  (tag_raddr),
    .tag_rdata  (tag_rdata),
    .tag_wr     (tag_wr)
  );

  fsact_meta_ram u_meta (
    .clk   (clk),
    .rst   (rst),
    .raddr (meta_raddr),
    .rdata (meta_rdata),
    .wr    (meta_wr)
  );

  fsact_tag_ram u_tags (
    .clk   (clk),
    .raddr (tag_raddr),
    .rdata (tag_rdata),
    .wr    (tag_wr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res <= res;
    end
  end

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken but block not busy next cycle");

  // a result is only loaded when the result register can take it
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> out_free)
    else $error("result loaded over a waiting result");

  // a fresh result only appears from a request in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in progress");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result register not cleared by reset");

endmodule
`default_nettype wire

FILE: src/fsact_tag_ram.sv
// fsact_tag_ram: tag and dirty storage, one entry per way of every set
// depends on fsact_pkg; contents are undefined until written
`default_nettype none
module fsact_tag_ram (
  input  wire logic                          clk,
  input  wire logic [fsact_pkg::SLOT_W-1:0]  raddr,
  output fsact_pkg::entry_t                  rdata,
  input  fsact_pkg::tag_wr_t                 wr
);

  fsact_pkg::entry_t mem [fsact_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/fsact_meta_ram.sv
// fsact_meta_ram: per-set fill count and oldest-way pointer
// depends on fsact_pkg; a set never written reads as empty via its valid bit
`default_nettype none
module fsact_meta_ram (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [fsact_pkg::SET_W-1:0]  raddr,
  output fsact_pkg::meta_t                  rdata,
  input  fsact_pkg::meta_wr_t               wr
);

  fsact_pkg::meta_t              mem [fsact_pkg::SETS];
  logic [fsact_pkg::SETS-1:0]    vld;
  fsact_pkg::meta_t              mem_q;
  logic                          vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set] <= wr.data;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.set] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  assign rdata = vld_q ? mem_q : '0;

endmodule
`default_nettype wire

FILE: src/fsact_ctrl.sv
// fsact_ctrl: request sequencer with the shared tag comparator
// depends on fsact_pkg; drives fsact_tag_ram and fsact_meta_ram
`default_nettype none
module fsact_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  idle,
  input  wire logic [1:0]                       req_type,
  input  wire logic [fsact_pkg::ADDR_BITS-1:0]  addr,
  input  wire logic                             fill_dirty,
  input  wire logic                             out_free,
  output logic                                  done,
  output fsact_pkg::outcome_t                   res,
  output logic [fsact_pkg::SET_W-1:0]           meta_raddr,
  input  fsact_pkg::meta_t                      meta_rdata,
  output fsact_pkg::meta_wr_t                   meta_wr,
  output logic [fsact_pkg::SLOT_W-1:0]          tag_raddr,
  input  fsact_pkg::entry_t                     tag_rdata,
  output fsact_pkg::tag_wr_t                    tag_wr
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_META  = 5'b00010,
    S_CHECK = 5'b00100,
    S_EVICT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic [fsact_pkg::SET_W-1:0]     req_set;
  logic [fsact_pkg::TAG_W-1:0]     req_tag;
  logic                            req_dirty;
  logic                            is_fill;
  logic                            is_write;
  logic [fsact_pkg::WAY_W-1:0]     ptr;
  logic [fsact_pkg::WAY_W-1:0]     cur_way, cur_way_next;
  logic [fsact_pkg::CNT_W-1:0]     left, left_next;
  fsact_pkg::outcome_t             res_next;
  logic                            set_full;
  logic                            tag_match;
  logic [fsact_pkg::WAY_W-1:0]     newest_way;

  assign idle       = (state == S_IDLE);
  assign meta_raddr = addr[fsact_pkg::OFF_W +: fsact_pkg::SET_W];
  assign set_full   = (meta_rdata.cnt == fsact_pkg::CNT_W'(fsact_pkg::WAYS));
  assign tag_match  = (tag_rdata.tag == req_tag);
  // ring position just past the last valid entry
  assign newest_way = fsact_pkg::WAY_W'(meta_rdata.ptr + meta_rdata.cnt[fsact_pkg::WAY_W-1:0]);

  always_comb begin
    state_next   = state;
    cur_way_next = cur_way;
    left_next    = left;
    res_next     = res;
    done         = 1'b0;
    tag_raddr    = {req_set, cur_way};
    tag_wr       = '0;
    meta_wr      = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_META;
        end
      end
      S_META: begin
        if (is_fill) begin
          if (set_full) begin
            tag_raddr  = {req_set, meta_rdata.ptr};
            state_next = S_EVICT;
          end else begin
            tag_wr.en         = 1'b1;
            tag_wr.slot       = {req_set, newest_way};
            tag_wr.data.tag   = req_tag;
            tag_wr.data.dirty = req_dirty;
            meta_wr.en        = 1'b1;
            meta_wr.set       = req_set;
            meta_wr.data.cnt  = meta_rdata.cnt + fsact_pkg::CNT_W'(1);
            meta_wr.data.ptr  = meta_rdata.ptr;
            res_next          = fsact_pkg::OUT_NONE_REPLACED;
            state_next        = S_DONE;
          end
        end else if (meta_rdata.cnt == '0) begin
          res_next   = fsact_pkg::OUT_MISS;
          state_next = S_DONE;
        end else begin
          // newest entry first
          cur_way_next = newest_way - fsact_pkg::WAY_W'(1);
          left_next    = meta_rdata.cnt;
          tag_raddr    = {req_set, cur_way_next};
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (tag_match) begin
          if (is_write) begin
            tag_wr.en         = 1'b1;
            tag_wr.slot       = {req_set, cur_way};
            tag_wr.data.tag   = req_tag;
            tag_wr.data.dirty = 1'b1;
          end
          res_next   = fsact_pkg::OUT_HIT;
          state_next = S_DONE;
        end else if (left == fsact_pkg::CNT_W'(1)) begin
          res_next   = fsact_pkg::OUT_MISS;
          state_next = S_DONE;
        end else begin
          cur_way_next = cur_way - fsact_pkg::WAY_W'(1);
          left_next    = left - fsact_pkg::CNT_W'(1);
          tag_raddr    = {req_set, cur_way_next};
        end
      end
      S_EVICT: begin
        res_next          = tag_rdata.dirty ? fsact_pkg::OUT_DIRTY_REPLACED
                                            : fsact_pkg::OUT_CLEAN_REPLACED;
        tag_wr.en         = 1'b1;
        tag_wr.slot       = {req_set, ptr};
        tag_wr.data.tag   = req_tag;
        tag_wr.data.dirty = req_dirty;
        meta_wr.en        = 1'b1;
        meta_wr.set       = req_set;
        meta_wr.data.cnt  = fsact_pkg::CNT_W'(fsact_pkg::WAYS);
        meta_wr.data.ptr  = ptr + fsact_pkg::WAY_W'(1);
        state_next        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_way <= cur_way_next;
    left    <= left_next;
    res     <= res_next;
    if (state == S_IDLE) begin
      req_set   <= addr[fsact_pkg::OFF_W +: fsact_pkg::SET_W];
      req_tag   <= addr[fsact_pkg::ADDR_BITS-1 : fsact_pkg::OFF_W + fsact_pkg::SET_W];
      req_dirty <= fill_dirty;
      is_fill   <= (req_type == fsact_pkg::REQ_FILL);
      is_write  <= (req_type == fsact_pkg::REQ_WRITE);
    end
    if (state == S_META) begin
      ptr <= meta_rdata.ptr;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// tb: self-checking bench for fifo_set_assoc_cache_tags_core, the fifo-replacement tag directory
// depends on fsact_pkg for widths, request and outcome codes; holds its own directory predictor
// directed lookups, fills and evictions first, then random traffic over a few busy sets
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsact_pkg::*;

  // predicted directory plus the queue of outcomes still owed by the block
  class dir_scoreboard;
    bit [TAG_W-1:0] tag_q [SETS][WAYS];
    bit             dirty_q [SETS][WAYS];
    int unsigned    fill_cnt [SETS];
    int unsigned    oldest_way [SETS];
    outcome_t       pending_outcomes [$];
    int unsigned    mismatches;

    // predict the outcome of one accepted request and update the directory copy
    function void note_request(req_type_t kind, logic [ADDR_BITS-1:0] a, logic dirty);
      logic [ADDR_BITS-OFF_W-1:0] blk;
      int unsigned                set_idx;
      bit [TAG_W-1:0]             tag;
      int unsigned                n;
      int unsigned                way;
      outcome_t                   res;
      blk     = a[ADDR_BITS-1:OFF_W];
      set_idx = 32'(blk % SETS);
      tag     = TAG_W'(blk / SETS);
      n       = fill_cnt[set_idx];
      if (kind == REQ_FILL) begin
        res = OUT_NONE_REPLACED;
        if (n >= WAYS) begin
          way = oldest_way[set_idx];
          res = dirty_q[set_idx][way] ? OUT_DIRTY_REPLACED : OUT_CLEAN_REPLACED;
          oldest_way[set_idx] = (way + 1) % WAYS;
        end else begin
          way = (oldest_way[set_idx] + n) % WAYS;
          fill_cnt[set_idx] = n + 1;
        end
        tag_q[set_idx][way]   = tag;
        dirty_q[set_idx][way] = dirty;
      end else begin
        // newest to oldest, the spare code behaves as a read
        res = OUT_MISS;
        for (int k = n; k > 0; k--) begin
          way = (oldest_way[set_idx] + k - 1) % WAYS;
          if (res == OUT_MISS && tag_q[set_idx][way] == tag) begin
            if (kind == REQ_WRITE) dirty_q[set_idx][way] = 1'b1;
            res = OUT_HIT;
          end
        end
      end
      pending_outcomes.push_back(res);
    endfunction

    function void check_outcome(logic [2:0] got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: result %0d with no request outstanding", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: outcome mismatch, expected %0d (%s) got %0d", want, want.name(), got);
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_outcomes.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           req_type = REQ_READ;
  logic [ADDR_BITS-1:0] addr = '0;
  logic                 fill_dirty = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           outcome;

  // set during the stretch where neither side idles
  bit                   calm = 1'b0;
  dir_scoreboard        sb;
  bit [TAG_W-1:0]       tag_pool [8];

  fifo_set_assoc_cache_tags_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .addr       (addr),
    .fill_dirty (fill_dirty),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .outcome    (outcome)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 22);
    end
  end

  // every result taken at a rising edge is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_outcome(outcome);
  end

  // build a byte address from its tag, set index and block offset
  function automatic logic [ADDR_BITS-1:0] mk_addr(bit [TAG_W-1:0] tag, int unsigned set_idx,
                                                   int unsigned off);
    logic [SET_W-1:0] s;
    logic [OFF_W-1:0] o;
    s = SET_W'(set_idx);
    o = OFF_W'(off);
    return {tag, s, o};
  endfunction

  // present one request from a falling edge, hold it until taken, return on the next fall
  task automatic send_request(req_type_t kind, logic [ADDR_BITS-1:0] a, logic dirty);
    bit taken;
    taken = 1'b0;
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    addr       <= a;
    fill_dirty <= dirty;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    sb.note_request(kind, a, dirty);
    @(negedge clk);
  endtask

  // one random request: mostly busy sets and a small tag pool so hits and evictions are common
  task automatic send_random();
    int unsigned r;
    int unsigned set_idx;
    req_type_t   kind;
    logic [ADDR_BITS-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 40)      kind = REQ_FILL;
    else if (r < 70) kind = REQ_READ;
    else if (r < 93) kind = REQ_WRITE;
    else             kind = REQ_SPARE;
    if ($urandom_range(0, 99) < 80) set_idx = $urandom_range(0, 3);
    else                            set_idx = $urandom_range(0, SETS - 1);
    a = mk_addr(tag_pool[$urandom_range(0, 7)], set_idx, $urandom_range(0, BLOCK_BYTES - 1));
    // occasional noise: a wholly random address
    if ($urandom_range(0, 99) < 10) a = $urandom;
    send_request(kind, a, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    bit [TAG_W-1:0] ta, tb_, tc, td, te, tf, tg;
    int unsigned    quiet_from;
    sb = new();
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = TAG_W'($urandom);
    ta = 20'h00001; tb_ = 20'h80000; tc = 20'h55555; td = 20'haaaaa;
    te = 20'h0f0f0; tf = 20'hf0f0f; tg = 20'h12345;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lowest address: miss on an empty set, fill, then read, spare code and write hit
    send_request(REQ_READ,  '0, 1'b0);
    send_request(REQ_FILL,  '0, 1'b0);
    send_request(REQ_READ,  '0, 1'b0);
    send_request(REQ_SPARE, '0, 1'b1);
    send_request(REQ_WRITE, mk_addr('0, 0, BLOCK_BYTES - 1), 1'b0);
    // highest address: last set, all-ones tag
    send_request(REQ_FILL,  '1, 1'b1);
    send_request(REQ_READ,  '1, 1'b0);
    send_request(REQ_SPARE, mk_addr('1, SETS - 1, 0), 1'b0);

    // duplicate fill of one tag, then fill the set up
    send_request(REQ_FILL,  mk_addr(ta, 1, 0), 1'b0);
    send_request(REQ_FILL,  mk_addr(ta, 1, 7), 1'b1);
    send_request(REQ_FILL,  mk_addr(tb_, 1, 0), 1'b0);
    send_request(REQ_FILL,  mk_addr(tc, 1, 0), 1'b0);
    send_request(REQ_WRITE, mk_addr(tb_, 1, 3), 1'b0);
    send_request(REQ_READ,  mk_addr(ta, 1, 0), 1'b0);
    // full set: clean copy goes first, then the dirty duplicate, then the written entry
    send_request(REQ_FILL,  mk_addr(td, 1, 0), 1'b0);
    send_request(REQ_FILL,  mk_addr(te, 1, 0), 1'b1);
    send_request(REQ_READ,  mk_addr(ta, 1, 0), 1'b0);
    send_request(REQ_FILL,  mk_addr(tf, 1, 0), 1'b0);
    send_request(REQ_FILL,  mk_addr(tg, 1, 0), 1'b0);
    send_request(REQ_READ,  mk_addr(td, 1, 0), 1'b0);
    send_request(REQ_WRITE, mk_addr(tc, 1, 0), 1'b0);
    send_request(REQ_WRITE, mk_addr(te, 1, 0), 1'b0);
    // same block index in a neighbouring set must not hit
    send_request(REQ_READ,  mk_addr(td, 2, 0), 1'b0);

    // random traffic with one long stretch without idling on either side
    quiet_from = $urandom_range(250, 500);
    for (int i = 0; i < 850; i++) begin
      calm = (i >= quiet_from) && (i < quiet_from + 150);
      send_random();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then allow for any stray result
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
